// File: rtl/midi_cmp_pkg.sv
// ----------------------------------------------------------------------------
// midi_cmp_pkg
// Shared types and codes for the MIDI channel message parser.
// ----------------------------------------------------------------------------
package midi_cmp_pkg;

    // widths of the item fields
    localparam int ByteW    = 8;
    localparam int KindW    = 2;
    localparam int ChannelW = 4;
    localparam int DataW    = 7;
    localparam int BendW    = 14;

    // status groups (high nibble of a status byte)
    localparam logic [3:0] GRP_NOTE_OFF = 4'h8;
    localparam logic [3:0] GRP_NOTE_ON  = 4'h9;
    localparam logic [3:0] GRP_PROGRAM  = 4'hC;
    localparam logic [3:0] GRP_BEND     = 4'hE;

    // event kinds on the result side
    localparam logic [KindW-1:0] KIND_NOTE_OFF = 2'd0;
    localparam logic [KindW-1:0] KIND_NOTE_ON  = 2'd1;
    localparam logic [KindW-1:0] KIND_PROGRAM  = 2'd2;
    localparam logic [KindW-1:0] KIND_BEND     = 2'd3;

    // one decoded event
    typedef struct packed {
        logic [BendW-1:0]    bend_value;
        logic [DataW-1:0]    velocity;
        logic [DataW-1:0]    key_or_program;
        logic [ChannelW-1:0] channel;
        logic [KindW-1:0]    event_kind;
    } midi_event_t;

endpackage

// File: rtl/midi_channel_message_parser_core.sv
// ----------------------------------------------------------------------------
// midi_channel_message_parser_core
// Decodes a raw MIDI byte stream into note, program and pitch bend events.
// ----------------------------------------------------------------------------
// Usage: feed one MIDI byte per item on the s_ channel; each completed note
// off, note on, program change or pitch bend message yields one event item on
// the m_ channel. A status byte starts a new message and drops any unfinished
// one; data bytes without a supported status are discarded, and running
// status is not supported. A note on with velocity zero comes out as a note
// off. The block takes one byte per cycle: a byte passes an input register
// and then a result register, so an event is held in the result register once
// the byte that completes it has left the input register. A byte only waits
// when the result register still holds an event the sink has not taken.
module midi_channel_message_parser_core
    import midi_cmp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // input channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] midi_byte
    // result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [3:0] channel, [10:4] key_or_program,
                                   // [17:11] velocity, [31:18] bend_value
    output logic [1:0]  m_tuser    // [1:0] event_kind
);

    // input register
    logic             in_valid_reg;
    logic [ByteW-1:0] in_byte_reg;

    // message state
    logic [ByteW-1:0] held_status_reg, held_status_next;
    logic             data_seen_reg, data_seen_next;
    logic [DataW-1:0] first_data_reg, first_data_next;

    // result register
    logic        out_valid_reg;
    midi_event_t out_event_reg;
    midi_event_t event_next;

    logic       advance;
    logic       emit;
    logic [3:0] group;
    logic       two_byte;
    logic [DataW-1:0] d1;
    logic [DataW-1:0] d2;

    // the held byte moves on when the result slot is free or being drained
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
        end
    end

    // decode the held byte against the current message state
    always_comb begin
        group    = held_status_reg[7:4];
        two_byte = (group == GRP_NOTE_OFF) || (group == GRP_NOTE_ON) ||
                   (group == GRP_BEND);
        d1       = two_byte ? first_data_reg : in_byte_reg[DataW-1:0];
        d2       = two_byte ? in_byte_reg[DataW-1:0] : '0;

        held_status_next = held_status_reg;
        data_seen_next   = data_seen_reg;
        first_data_next  = first_data_reg;
        emit             = 1'b0;

        event_next                = '0;
        event_next.channel        = held_status_reg[3:0];
        event_next.key_or_program = d1;

        if (in_byte_reg[7]) begin
            // status byte: start a new message
            held_status_next = in_byte_reg;
            data_seen_next   = 1'b0;
            first_data_next  = '0;
        end else if (two_byte && !data_seen_reg) begin
            // first of two data bytes
            first_data_next = in_byte_reg[DataW-1:0];
            data_seen_next  = 1'b1;
        end else if (two_byte || group == GRP_PROGRAM) begin
            // message complete
            emit             = 1'b1;
            held_status_next = '0;
            data_seen_next   = 1'b0;
            first_data_next  = '0;
        end

        // event fields by group
        case (group)
            GRP_NOTE_OFF: begin
                event_next.event_kind = KIND_NOTE_OFF;
            end
            GRP_NOTE_ON: begin
                if (d2 == '0) begin
                    event_next.event_kind = KIND_NOTE_OFF;
                end else begin
                    event_next.event_kind = KIND_NOTE_ON;
                    event_next.velocity   = d2;
                end
            end
            GRP_PROGRAM: begin
                event_next.event_kind = KIND_PROGRAM;
            end
            default: begin
                event_next.event_kind     = KIND_BEND;
                event_next.key_or_program = '0;
                event_next.bend_value     = {d2, d1};
            end
        endcase
    end

    // message state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_status_reg <= '0;
            data_seen_reg   <= 1'b0;
            first_data_reg  <= '0;
        end else if (advance) begin
            held_status_reg <= held_status_next;
            data_seen_reg   <= data_seen_next;
            first_data_reg  <= first_data_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance && emit) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
        if (advance && emit) begin
            out_event_reg <= event_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_event_reg.event_kind;
    assign m_tdata  = {out_event_reg.bend_value, out_event_reg.velocity,
                       out_event_reg.key_or_program, out_event_reg.channel};

    // first data byte is only held for a two-byte message
    a_seen_two_byte: assert property (@(posedge aclk) disable iff (!aresetn)
        data_seen_reg |-> (held_status_reg[7:4] == GRP_NOTE_OFF ||
                           held_status_reg[7:4] == GRP_NOTE_ON ||
                           held_status_reg[7:4] == GRP_BEND))
        else $error("data byte held without a two-byte status");

    // a completed message clears the held status
    a_clear_after_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && emit) |=> (held_status_reg == '0 && !data_seen_reg))
        else $error("status still held after an event");

    // a note on event never carries zero velocity
    a_note_on_vel: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == KIND_NOTE_ON) |-> (m_tdata[17:11] != '0))
        else $error("note on with zero velocity");

    // only pitch bend carries a bend value
    a_bend_only: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser != KIND_BEND) |-> (m_tdata[31:18] == '0))
        else $error("bend value on a non-bend event");

    // an event is loaded only into a free or draining result slot
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && emit) |-> (!out_valid_reg || m_tready))
        else $error("result register overwritten");

endmodule

// File: tb/midi_event_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// midi_event_checker
// Watches both channels of the MIDI parser, decodes every accepted byte on
// its own copy of the parser state and compares each event item field by
// field with the oldest expected event.
// ----------------------------------------------------------------------------
module midi_event_checker
    import midi_cmp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [31:0] m_tdata,
    input  logic [1:0]  m_tuser,
    output int          mismatches,
    output int          pending,
    output int          events_checked
);

    // parser state as seen from the byte stream
    logic [7:0]       held_status;
    logic             have_first;
    logic [DataW-1:0] first_data;

    // decoded events still waiting for their item on the result channel
    midi_event_t expected_events[$];

    // one line per mismatch, and count it
    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch at %0t: %s got 0x%0h expected 0x%0h", $realtime, what, got, want);
        mismatches = mismatches + 1;
    endtask

    // queue one event and drop the message in progress
    task automatic emit_event(input logic [KindW-1:0] kind, input logic [DataW-1:0] key,
                              input logic [DataW-1:0] vel, input logic [BendW-1:0] bend);
        midi_event_t ev;
        ev.event_kind     = kind;
        ev.channel        = held_status[3:0];
        ev.key_or_program = key;
        ev.velocity       = vel;
        ev.bend_value     = bend;
        expected_events.push_back(ev);
        held_status = '0;
        have_first  = 1'b0;
        first_data  = '0;
    endtask

    // advance the parser by one byte
    task automatic decode_byte(input logic [7:0] b);
        logic [DataW-1:0] d;
        d = b[6:0];
        if (b[7]) begin
            // any status restarts collection
            held_status = b;
            have_first  = 1'b0;
            first_data  = '0;
        end else begin
            case (held_status[7:4])
                GRP_PROGRAM: begin
                    emit_event(KIND_PROGRAM, d, '0, '0);
                end
                GRP_NOTE_OFF, GRP_NOTE_ON, GRP_BEND: begin
                    if (!have_first) begin
                        first_data = d;
                        have_first = 1'b1;
                    end else if (held_status[7:4] == GRP_NOTE_OFF) begin
                        emit_event(KIND_NOTE_OFF, first_data, '0, '0);
                    end else if (held_status[7:4] == GRP_BEND) begin
                        emit_event(KIND_BEND, '0, '0, {d, first_data});
                    end else if (d == '0) begin
                        // note on with zero velocity is a note off
                        emit_event(KIND_NOTE_OFF, first_data, '0, '0);
                    end else begin
                        emit_event(KIND_NOTE_ON, first_data, d, '0);
                    end
                end
                default: begin
                    // no status, or one the parser does not decode
                end
            endcase
        end
    endtask

    // compare one event item with the oldest expectation
    task automatic check_event();
        midi_event_t want;
        if (expected_events.size() == 0) begin
            report_mismatch("event item with nothing expected, tdata", m_tdata, '0);
        end else begin
            want = expected_events.pop_front();
            events_checked = events_checked + 1;
            if (m_tuser != want.event_kind)
                report_mismatch("event_kind", m_tuser, want.event_kind);
            if (m_tdata[3:0] != want.channel)
                report_mismatch("channel", m_tdata[3:0], want.channel);
            if (m_tdata[10:4] != want.key_or_program)
                report_mismatch("key_or_program", m_tdata[10:4], want.key_or_program);
            if (m_tdata[17:11] != want.velocity)
                report_mismatch("velocity", m_tdata[17:11], want.velocity);
            if (m_tdata[31:18] != want.bend_value)
                report_mismatch("bend_value", m_tdata[31:18], want.bend_value);
        end
    endtask

    // sample both channels at the rising edge
    always @(posedge aclk) begin
        if (!aresetn) begin
            held_status    = '0;
            have_first     = 1'b0;
            first_data     = '0;
            mismatches     = 0;
            events_checked = 0;
            expected_events.delete();
        end else begin
            if (s_tvalid && s_tready)
                decode_byte(s_tdata);
            if (m_tvalid && m_tready)
                check_event();
        end
        pending = expected_events.size();
    end

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives MIDI byte streams into the channel message parser: a short opening
// of hand-picked messages and corner cases, then random messages mixed with
// truncated runs, unsupported statuses and stray bytes, with random stalls
// on both sides. The checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module tb_top;
    import midi_cmp_pkg::*;

    // status groups the parser does not decode
    localparam logic [3:0] GRP_POLY_PRESSURE = 4'hA;
    localparam logic [3:0] GRP_CONTROL       = 4'hB;
    localparam logic [3:0] GRP_CHAN_PRESSURE = 4'hD;
    localparam logic [3:0] GRP_SYSTEM        = 4'hF;

    localparam int RandomBytes = 1350;
    localparam int CycleLimit  = 200000;
    localparam int IdlePct     = 32;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;
    logic [1:0]  m_tuser;

    int mismatches;
    int pending;
    int events_checked;
    int cycles;
    int bytes_sent;
    int decoded_bytes;
    logic calm;

    midi_channel_message_parser_core dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    midi_event_checker checker_i (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tuser        (m_tuser),
        .mismatches     (mismatches),
        .pending        (pending),
        .events_checked (events_checked)
    );

    // 12 ns clock
    always begin
        aclk = 1'b0;
        #6;
        aclk = 1'b1;
        #6;
    end

    // run-away guard
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit) begin
            $display("timeout after %0d cycles, %0d events outstanding", cycles, pending);
            $display("** midi_channel_message_parser_core: FAILED **");
            $finish;
        end
    end

    // sink stalls at random except in the calm stretch
    always @(negedge aclk) begin
        m_tready <= calm || ($urandom_range(99) >= IdlePct);
    end

    // present one byte, with a random gap first, and hold it until taken
    task automatic send_byte(input logic [7:0] b);
        while (!calm && $urandom_range(99) < IdlePct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(posedge aclk); while (!s_tready);
        bytes_sent = bytes_sent + 1;
        @(negedge aclk);
    endtask

    // one random run: mostly complete messages, some broken ones and noise
    task automatic send_random_run();
        int r;
        int n;
        int start_cnt;
        logic [3:0] grp;
        logic [3:0] ch;
        logic [6:0] d1;
        logic [6:0] d2;
        r  = $urandom_range(99);
        ch = 4'($urandom_range(15));
        d1 = 7'($urandom_range(127));
        d2 = 7'($urandom_range(127));
        case ($urandom_range(3))
            0:       grp = GRP_NOTE_OFF;
            1:       grp = GRP_NOTE_ON;
            2:       grp = GRP_PROGRAM;
            default: grp = GRP_BEND;
        endcase
        if (grp == GRP_NOTE_ON && $urandom_range(99) < 15)
            d2 = '0;
        start_cnt = bytes_sent;
        if (r < 72) begin
            // complete message, now and then with a stray data byte after it
            send_byte({grp, ch});
            send_byte({1'b0, d1});
            if (grp != GRP_PROGRAM)
                send_byte({1'b0, d2});
            if ($urandom_range(99) < 8)
                send_byte({1'b0, 7'($urandom_range(127))});
            decoded_bytes += bytes_sent - start_cnt;
        end else if (r < 82) begin
            // message cut short by whatever status comes next
            send_byte({grp, ch});
            if (grp != GRP_PROGRAM && $urandom_range(1) == 1)
                send_byte({1'b0, d1});
            decoded_bytes += bytes_sent - start_cnt;
        end else if (r < 92) begin
            // status the parser ignores, with some data
            case ($urandom_range(3))
                0:       grp = GRP_POLY_PRESSURE;
                1:       grp = GRP_CONTROL;
                2:       grp = GRP_CHAN_PRESSURE;
                default: grp = GRP_SYSTEM;
            endcase
            send_byte({grp, ch});
            n = $urandom_range(2);
            repeat (n) send_byte({1'b0, 7'($urandom_range(127))});
        end else begin
            send_byte(8'($urandom));
        end
    endtask

    // hand-picked opening: extremes, every kind and the odd cases
    logic [7:0] opening[$];

    initial begin
        aresetn       = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        m_tready      = 1'b0;
        calm          = 1'b0;
        cycles        = 0;
        bytes_sent    = 0;
        decoded_bytes = 0;

        opening = '{
            8'h45,                                        // data with no status
            {GRP_NOTE_ON, 4'h0}, 8'h00, 8'h7F,            // note on, lowest key, top vel
            {GRP_NOTE_ON, 4'hF}, 8'h7F, 8'h00,            // zero velocity note on
            {GRP_NOTE_OFF, 4'hA}, 8'h3C, 8'h40,           // note off
            8'h12,                                        // data after a finished message
            {GRP_PROGRAM, 4'h0}, 8'h7F,                   // program change
            {GRP_BEND, 4'h0}, 8'h00, 8'h00,               // lowest bend
            {GRP_BEND, 4'hF}, 8'h7F, 8'h7F,               // highest bend
            {GRP_NOTE_ON, 4'h1}, 8'h40,                   // dropped by the next status
            {GRP_PROGRAM, 4'h5}, 8'h2A,
            {GRP_POLY_PRESSURE, 4'h5}, 8'h10,             // ignored group
            {GRP_SYSTEM, 4'h8}, 8'h01                     // real-time byte, then data
        };

        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (opening[i])
            send_byte(opening[i]);

        // random part with one stretch where neither side idles
        while (bytes_sent < RandomBytes) begin
            calm = (bytes_sent >= 500 && bytes_sent < 700);
            send_random_run();
        end
        calm = 1'b0;
        s_tvalid <= 1'b0;

        // drain, then wait on to catch stray events
        while (pending != 0)
            @(negedge aclk);
        repeat (10) @(negedge aclk);

        $display("run covered %0d bytes (%0d opening, %0d in decodable runs)",
                 bytes_sent, opening.size(), decoded_bytes);
        $display("%0d events compared, %0d mismatches", events_checked, mismatches);
        if (mismatches == 0) begin
            $display("** midi_channel_message_parser_core: PASSED **");
        end else begin
            $display("** midi_channel_message_parser_core: FAILED **");
        end
        $finish;
    end

endmodule
